/* rtl/ppk_pkg.sv */
// Package for the UVC payload packetizer: constants, register codes and the
// record type passed from the front end to the back end. No dependencies.
`timescale 1ns / 1ps
package ppk_pkg;

  localparam int FRAME_COUNT_BITS = 24;
  localparam int FRAME_BYTES_W    = 24;
  localparam int LIMIT_W          = 10;
  // compare width: room for frame counter plus limit without overflow
  localparam int CMP_W = ((FRAME_COUNT_BITS > FRAME_BYTES_W) ?
                          FRAME_COUNT_BITS : FRAME_BYTES_W) + 2;

  localparam logic [CMP_W-1:0] FRAME_CAP =
    {{(CMP_W-1){1'b0}}, 1'b1} << FRAME_COUNT_BITS;

  localparam logic [FRAME_BYTES_W-1:0] FRAME_BYTES_RST = 24'd320000;
  localparam logic [LIMIT_W-1:0]       PAYLOAD_LIMIT_RST = 10'd510;
  localparam logic [LIMIT_W-1:0]       LIMIT_MAX = 10'd1022;

  localparam logic [7:0] HDR_LEN_BYTE = 8'h02;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REG_FRAME_BYTES   = 1'b0,
    REG_PAYLOAD_LIMIT = 1'b1
  } ppk_reg_t;

  // effective (clamped) configuration seen by the front end
  typedef struct packed {
    logic [CMP_W-1:0]   fsize;
    logic [LIMIT_W-1:0] limit;
  } ppk_cfg_t;

  // one classified input item
  typedef struct packed {
    logic       hdr;    // first byte of a packet: emit header first
    logic       eof;    // EOF flag for the info byte
    logic       fid;    // frame-ID toggle for the info byte
    logic [7:0] data;
    logic       pend;   // last byte of its packet
    logic       fend;   // last byte of its frame
  } ppk_rec_t;

endpackage

/* rtl/ppk_if.sv */
// Stream interfaces for the packetizer: frame bytes in, packet bytes out.
// Depends on nothing.
`timescale 1ns / 1ps
interface ppk_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface ppk_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_header;
  logic       packet_last;
  logic       frame_last;

  modport source (output valid, output out_byte, output is_header,
                  output packet_last, output frame_last, input ready);
  modport sink   (input valid, input out_byte, input is_header,
                  input packet_last, input frame_last, output ready);
endinterface

/* rtl/ppk_regs.sv */
// APB register file for the packetizer: frame size and payload limit, with
// clamping to the effective values. Depends on ppk_pkg.
`timescale 1ns / 1ps
module ppk_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppk_pkg::PADDR_W-1:0] paddr,
  input  logic [ppk_pkg::PDATA_W-1:0] pwdata,
  output logic [ppk_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  output ppk_pkg::ppk_cfg_t           cfg
);
  import ppk_pkg::*;

  logic [FRAME_BYTES_W-1:0] frame_bytes;
  logic [LIMIT_W-1:0]       payload_limit;
  logic                     wr;
  ppk_reg_t                 sel;
  logic [CMP_W-1:0]         fb_ext;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign sel    = ppk_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bytes   <= FRAME_BYTES_RST;
      payload_limit <= PAYLOAD_LIMIT_RST;
    end else if (wr) begin
      unique case (sel)
        REG_FRAME_BYTES:   frame_bytes   <= pwdata[FRAME_BYTES_W-1:0];
        REG_PAYLOAD_LIMIT: payload_limit <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_FRAME_BYTES:   prdata = PDATA_W'(frame_bytes);
      REG_PAYLOAD_LIMIT: prdata = PDATA_W'(payload_limit);
      default:           prdata = '0;
    endcase
  end

  // zero acts as one; frame size capped at the counter range
  assign fb_ext = (frame_bytes == '0) ? CMP_W'(1) : CMP_W'(frame_bytes);

  always_comb begin
    cfg.fsize = (fb_ext > FRAME_CAP) ? FRAME_CAP : fb_ext;
    if (payload_limit == '0) begin
      cfg.limit = LIMIT_W'(1);
    end else if (payload_limit > LIMIT_MAX) begin
      cfg.limit = LIMIT_MAX;
    end else begin
      cfg.limit = payload_limit;
    end
  end

endmodule

/* rtl/ppk_front.sv */
// Front end: accepts frame bytes, tracks frame/packet counters and the
// frame-ID bit, and emits one classified record per byte. Depends on ppk_pkg.
`timescale 1ns / 1ps
module ppk_front (
  input  logic              clk,
  input  logic              rst,
  input  ppk_pkg::ppk_cfg_t cfg,
  ppk_byte_if.sink          video,
  input  logic              fifo_full,
  output logic              push,
  output ppk_pkg::ppk_rec_t rec
);
  import ppk_pkg::*;

  logic [FRAME_COUNT_BITS-1:0] frame_count;
  logic [LIMIT_W-1:0]          packet_count;
  logic                        frame_toggle;

  logic [CMP_W-1:0]   fc_inc;
  logic [CMP_W-1:0]   fc_reach;
  logic [LIMIT_W-1:0] pc_inc;
  logic               fend;
  logic               pend;

  assign video.ready = !fifo_full;
  assign push        = video.valid && !fifo_full;

  assign fc_inc   = CMP_W'(frame_count) + CMP_W'(1);
  assign fc_reach = CMP_W'(frame_count) + CMP_W'(cfg.limit);
  assign pc_inc   = packet_count + LIMIT_W'(1);
  assign fend     = fc_inc >= cfg.fsize;
  assign pend     = fend || (pc_inc >= cfg.limit);

  always_comb begin
    rec.hdr  = (packet_count == '0);
    rec.eof  = fc_reach >= cfg.fsize;
    rec.fid  = frame_toggle;
    rec.data = video.data_byte;
    rec.pend = pend;
    rec.fend = fend;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count  <= '0;
      packet_count <= '0;
      frame_toggle <= 1'b0;
    end else if (push) begin
      frame_count  <= fend ? '0 : fc_inc[FRAME_COUNT_BITS-1:0];
      packet_count <= pend ? '0 : pc_inc;
      if (fend) begin
        frame_toggle <= !frame_toggle;
      end
    end
  end

endmodule

/* rtl/ppk_fifo.sv */
// Short record queue between front and back ends.
// Depends on ppk_pkg.
`timescale 1ns / 1ps
module ppk_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  ppk_pkg::ppk_rec_t wdata,
  input  logic              pop,
  output ppk_pkg::ppk_rec_t rdata,
  output logic              full,
  output logic              empty
);
  import ppk_pkg::*;

  ppk_rec_t           mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_CW-1:0] count;

  assign full  = (count == FIFO_CW'(FIFO_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + FIFO_AW'(1);
      if (pop)  rptr <= rptr + FIFO_AW'(1);
      priority case (1'b1)
        push && !pop: count <= count + FIFO_CW'(1);
        pop && !push: count <= count - FIFO_CW'(1);
        default: ;
      endcase
    end
  end

endmodule

/* rtl/ppk_back.sv */
// Back end: expands each record into header and data bytes and holds them in
// an output register. Depends on ppk_pkg.
`timescale 1ns / 1ps
module ppk_back (
  input  logic              clk,
  input  logic              rst,
  input  ppk_pkg::ppk_rec_t rec,
  input  logic              empty,
  output logic              pop,
  ppk_pkt_if.source         bulk
);
  import ppk_pkg::*;

  typedef enum logic [2:0] {
    PH_LEN  = 3'b001,
    PH_INFO = 3'b010,
    PH_DATA = 3'b100
  } ppk_phase_t;

  ppk_phase_t phase;
  ppk_phase_t phase_next;
  logic       load;
  logic [7:0] byte_next;
  logic       hdr_next;

  logic       out_valid;
  logic [7:0] out_byte;
  logic       is_header;
  logic       packet_last;
  logic       frame_last;

  assign load = !empty && (!out_valid || bulk.ready);

  always_comb begin
    phase_next = phase;
    pop        = 1'b0;
    byte_next  = rec.data;
    hdr_next   = 1'b0;
    unique case (phase)
      PH_LEN: begin
        if (rec.hdr) begin
          byte_next  = HDR_LEN_BYTE;
          hdr_next   = 1'b1;
          phase_next = PH_INFO;
        end else begin
          pop = load;
        end
      end
      PH_INFO: begin
        byte_next  = {6'b0, rec.eof, rec.fid};
        hdr_next   = 1'b1;
        phase_next = PH_DATA;
      end
      PH_DATA: begin
        pop        = load;
        phase_next = PH_LEN;
      end
      default: phase_next = PH_LEN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LEN;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        phase     <= phase_next;
        out_valid <= 1'b1;
      end else if (bulk.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_byte    <= byte_next;
      is_header   <= hdr_next;
      packet_last <= !hdr_next && rec.pend;
      frame_last  <= !hdr_next && rec.fend;
    end
  end

  assign bulk.valid       = out_valid;
  assign bulk.out_byte    = out_byte;
  assign bulk.is_header   = is_header;
  assign bulk.packet_last = packet_last;
  assign bulk.frame_last  = frame_last;

endmodule

/* rtl/uvc_payload_packetizer_core.sv */
// UVC payload packetizer: top level. Ties together the APB registers, the
// classifying front end, the record queue and the byte-expanding back end.
// Depends on ppk_pkg, ppk_if, ppk_regs, ppk_front, ppk_fifo, ppk_back.
//
// Usage:
//   video : frame bytes in, valid/ready, one item per byte in frame order.
//   bulk  : packet stream out, valid/ready; each packet is a length byte
//           (0x02), an info byte (bit 0 frame ID, bit 1 EOF) and then up to
//           payload_limit data bytes. packet_last marks the final byte of a
//           packet, frame_last the final data byte of a frame.
//   APB   : register 0 frame_bytes at 0x0, register 1 payload_limit at 0x4.
//           Write only while the block is idle.
// Path: an accepted item is written into the record queue, then loaded into
//   the output register, from which its first byte shows on bulk.
// Throughput: one output byte per cycle while the queue holds an item and
//   bulk is ready, set by the single output register; each packet header
//   adds a length and an info byte ahead of its data. The four-entry record
//   queue absorbs the header bytes so input bursts rarely see ready drop.
// Reset (rst, synchronous): counters, frame ID and queue cleared, registers
//   back to 320000 and 510, no output valid.
// Receiver stall: the output item holds; the queue fills, then video.ready
//   falls until the receiver drains it. Nothing is dropped.
`timescale 1ns / 1ps
module uvc_payload_packetizer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppk_pkg::PADDR_W-1:0] paddr,
  input  logic [ppk_pkg::PDATA_W-1:0] pwdata,
  output logic [ppk_pkg::PDATA_W-1:0] prdata,
  output logic                        pready,
  ppk_byte_if.sink                    video,
  ppk_pkt_if.source                   bulk
);
  import ppk_pkg::*;

  ppk_cfg_t cfg;
  ppk_rec_t rec_in;     // classified item from the front end
  ppk_rec_t rec_head;   // oldest queued item, seen by the back end
  logic     push;
  logic     pop;
  logic     full;
  logic     empty;

  ppk_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // front end: counters and classification; one item per cycle unless full
  ppk_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .video     (video),
    .fifo_full (full),
    .push      (push),
    .rec       (rec_in)
  );

  // decouples input acceptance from header insertion on the output
  ppk_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .wdata (rec_in),
    .pop   (pop),
    .rdata (rec_head),
    .full  (full),
    .empty (empty)
  );

  // back end: one output byte per cycle into output register when unstalled
  ppk_back u_back (
    .clk   (clk),
    .rst   (rst),
    .rec   (rec_head),
    .empty (empty),
    .pop   (pop),
    .bulk  (bulk)
  );

endmodule

/* rtl/ppk_chk.sv */
// Port-level checker for the packetizer, bound to the top level.
// Depends on ppk_pkg.
`timescale 1ns / 1ps
module ppk_chk (
  input logic       clk,
  input logic       rst,
  input logic       valid,
  input logic       ready,
  input logic [7:0] out_byte,
  input logic       is_header,
  input logic       packet_last,
  input logic       frame_last
);
  import ppk_pkg::*;

  // nothing comes out in the cycle after reset
  a_rst_quiet: assert property (@(posedge clk) $past(rst) |-> !valid)
    else $error("output valid right after reset");

  // header bytes never close a packet or a frame
  a_hdr_flags: assert property (@(posedge clk) disable iff (rst)
    (valid && is_header) |-> (!packet_last && !frame_last))
    else $error("header byte flagged as last");

  // end of frame always ends the packet
  a_eof_pkt: assert property (@(posedge clk) disable iff (rst)
    (valid && frame_last) |-> packet_last)
    else $error("frame_last without packet_last");

  // info byte carries only the frame-ID and EOF bits
  a_info_bits: assert property (@(posedge clk) disable iff (rst)
    (valid && is_header && out_byte != HDR_LEN_BYTE) |-> (out_byte[7:2] == 6'b0))
    else $error("reserved info bits set");

  // stalled output holds its byte
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (valid && !ready) |=> (valid && $stable(out_byte)))
    else $error("output changed while stalled");

endmodule

bind uvc_payload_packetizer_core ppk_chk u_chk (
  .clk         (clk),
  .rst         (rst),
  .valid       (bulk.valid),
  .ready       (bulk.ready),
  .out_byte    (bulk.out_byte),
  .is_header   (bulk.is_header),
  .packet_last (bulk.packet_last),
  .frame_last  (bulk.frame_last)
);
